FILE: hdl/fpp_pkg.sv
// Shared types, phase codes, character codes and helper functions of the FEN parser.
package fpp_pkg;

  localparam logic [3:0] PH_PLACE          = 4'd0;
  localparam logic [3:0] PH_COLOUR         = 4'd1;
  localparam logic [3:0] PH_CASTLE_START   = 4'd2;
  localparam logic [3:0] PH_CASTLE_LETTERS = 4'd3;
  localparam logic [3:0] PH_EP_START       = 4'd4;
  localparam logic [3:0] PH_EP_RANK        = 4'd5;
  localparam logic [3:0] PH_HALF_START     = 4'd6;
  localparam logic [3:0] PH_HALF_SIGN      = 4'd7;
  localparam logic [3:0] PH_HALF_DIGITS    = 4'd8;
  localparam logic [3:0] PH_MOVE_START     = 4'd9;
  localparam logic [3:0] PH_MOVE_SIGN      = 4'd10;
  localparam logic [3:0] PH_MOVE_DIGITS    = 4'd11;
  localparam logic [3:0] PH_DONE           = 4'd12;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_K  = 8'h4B;
  localparam logic [7:0] CH_UP_Q  = 8'h51;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_K  = 8'h6B;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_Q  = 8'h71;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_W  = 8'h77;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [3:0] PIECE_NONE = 4'd15;

  localparam logic [2:0] RANK_TOP   = 3'd7;
  localparam logic [2:0] RANK_THREE = 3'd2;
  localparam logic [2:0] RANK_SIX   = 3'd5;
  localparam logic [3:0] FILE_END   = 4'd8;

  localparam logic [3:0] CASTLE_WK = 4'b0001;
  localparam logic [3:0] CASTLE_WQ = 4'b0010;
  localparam logic [3:0] CASTLE_BK = 4'b0100;
  localparam logic [3:0] CASTLE_BQ = 4'b1000;

  localparam int TDATA_W = 56;

  typedef struct packed {
    logic [3:0]  phase;
    logic        err;
    logic [2:0]  rank;
    logic [3:0]  file;
    logic        colour;
    logic [3:0]  castle;
    logic        ep_flag;
    logic [5:0]  ep_sq;
    logic        neg;
    logic [15:0] clock_val;
    logic [15:0] moves_val;
  } fpp_state_t;

  typedef struct packed {
    logic               kind;
    logic [5:0]         square;
    logic [3:0]         piece;
    logic               status;
    logic               side;
    logic [3:0]         castle;
    logic               ep_valid;
    logic [5:0]         ep_square;
    logic signed [15:0] half_clock;
    logic signed [15:0] move_num;
  } fpp_result_t;

  localparam fpp_state_t FPP_STATE_RESET = '{
    phase: PH_PLACE, err: 1'b0, rank: RANK_TOP, file: 4'd0, colour: 1'b0,
    castle: 4'd0, ep_flag: 1'b0, ep_sq: 6'd0, neg: 1'b0,
    clock_val: 16'd0, moves_val: 16'd0
  };

  function automatic logic fpp_is_ws(input logic [7:0] c);
    return c inside {[CH_TAB:CH_CR], CH_SPACE};
  endfunction

  function automatic logic fpp_is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic [3:0] fpp_piece_of(input logic [7:0] c);
    logic [3:0] p;
    case (c)
      CH_UP_K: p = 4'd0;
      CH_UP_Q: p = 4'd1;
      CH_UP_R: p = 4'd2;
      CH_UP_B: p = 4'd3;
      CH_UP_N: p = 4'd4;
      CH_UP_P: p = 4'd5;
      CH_LO_K: p = 4'd6;
      CH_LO_Q: p = 4'd7;
      CH_LO_R: p = 4'd8;
      CH_LO_B: p = 4'd9;
      CH_LO_N: p = 4'd10;
      CH_LO_P: p = 4'd11;
      default: p = PIECE_NONE;
    endcase
    return p;
  endfunction

  // Computes old * 10 +/- digit on the signed value and saturates to 16 bits.
  function automatic logic [15:0] fpp_accumulate(input logic [15:0] old,
                                                 input logic [3:0] d,
                                                 input logic neg);
    logic signed [19:0] v;
    logic signed [19:0] dv;
    logic signed [19:0] t;
    logic [15:0]        r;
    v  = 20'(signed'(old));
    dv = signed'({16'd0, d});
    t  = (v <<< 3) + (v <<< 1);
    t  = neg ? (t - dv) : (t + dv);
    if (t > 20'sd32767) begin
      r = 16'h7FFF;
    end else if (t < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  // Handles the first byte seen while looking for the move number.
  function automatic fpp_state_t fpp_move_start(input fpp_state_t s, input logic [7:0] c);
    fpp_state_t n;
    n = s;
    if (fpp_is_ws(c)) begin
      n.phase = PH_MOVE_START;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      n.neg   = (c == CH_MINUS);
      n.phase = PH_MOVE_SIGN;
    end else if (fpp_is_digit(c)) begin
      n.neg       = 1'b0;
      n.moves_val = fpp_accumulate(16'd0, c[3:0], 1'b0);
      n.phase     = PH_MOVE_DIGITS;
    end else begin
      n.phase = PH_DONE;
    end
    return n;
  endfunction

endpackage

FILE: hdl/fpp_step.sv
// Next-state and result logic for one character or end transaction of the FEN parser.
module fpp_step
  import fpp_pkg::*;
(
  input  fpp_state_t  state_i,
  input  logic        mode_i,
  input  logic [7:0]  char_i,
  output fpp_state_t  state_nxt,
  output logic        res_valid,
  output fpp_result_t res
);

  logic       bad;
  logic [4:0] skip_sum;
  logic [3:0] piece;

  always_comb begin
    state_nxt = state_i;
    res_valid = 1'b0;
    res       = '0;
    bad       = state_i.err || (state_i.phase < PH_HALF_START);
    skip_sum  = {1'b0, state_i.file} + {1'b0, char_i[3:0]};
    piece     = fpp_piece_of(char_i);

    if (mode_i) begin
      res_valid  = 1'b1;
      res.kind   = 1'b1;
      res.status = bad;
      if (!bad) begin
        res.side       = state_i.colour;
        res.castle     = state_i.castle;
        res.ep_valid   = state_i.ep_flag;
        res.ep_square  = state_i.ep_flag ? state_i.ep_sq : 6'd0;
        res.half_clock = signed'(state_i.clock_val);
        res.move_num   = signed'(state_i.moves_val);
      end
      state_nxt = FPP_STATE_RESET;
    end else if (!state_i.err && state_i.phase < PH_DONE) begin
      case (state_i.phase)
        PH_PLACE: begin
          if (char_i == CH_SPACE) begin
            if (state_i.rank != 3'd0) begin
              state_nxt.err = 1'b1;
            end else begin
              state_nxt.phase = PH_COLOUR;
            end
          end else if (char_i == CH_SLASH) begin
            if (state_i.rank == 3'd0) begin
              state_nxt.err = 1'b1;
            end else begin
              state_nxt.rank = state_i.rank - 3'd1;
              state_nxt.file = 4'd0;
            end
          end else if (char_i inside {[CH_ONE:CH_EIGHT]}) begin
            if (skip_sum > {1'b0, FILE_END}) begin
              state_nxt.err = 1'b1;
            end else begin
              state_nxt.file = skip_sum[3:0];
            end
          end else if (piece == PIECE_NONE || state_i.file >= FILE_END) begin
            state_nxt.err = 1'b1;
          end else begin
            res_valid      = 1'b1;
            res.square     = {state_i.rank, state_i.file[2:0]};
            res.piece      = piece;
            state_nxt.file = state_i.file + 4'd1;
          end
        end
        PH_COLOUR: begin
          if (char_i == CH_LO_W) begin
            state_nxt.colour = 1'b0;
            state_nxt.phase  = PH_CASTLE_START;
          end else if (char_i == CH_LO_B) begin
            state_nxt.colour = 1'b1;
            state_nxt.phase  = PH_CASTLE_START;
          end else if (char_i != CH_SPACE) begin
            state_nxt.err = 1'b1;
          end
        end
        PH_CASTLE_START, PH_CASTLE_LETTERS: begin
          if (char_i == CH_SPACE) begin
            if (state_i.phase == PH_CASTLE_LETTERS) begin
              state_nxt.phase = PH_EP_START;
            end
          end else if (char_i == CH_MINUS && state_i.phase == PH_CASTLE_START) begin
            state_nxt.phase = PH_EP_START;
          end else begin
            state_nxt.phase = PH_CASTLE_LETTERS;
            case (char_i)
              CH_UP_K: state_nxt.castle = state_i.castle | CASTLE_WK;
              CH_UP_Q: state_nxt.castle = state_i.castle | CASTLE_WQ;
              CH_LO_K: state_nxt.castle = state_i.castle | CASTLE_BK;
              CH_LO_Q: state_nxt.castle = state_i.castle | CASTLE_BQ;
              default: begin
                state_nxt.err   = 1'b1;
                state_nxt.phase = state_i.phase;
              end
            endcase
          end
        end
        PH_EP_START: begin
          if (char_i == CH_MINUS) begin
            state_nxt.ep_flag = 1'b0;
            state_nxt.phase   = PH_HALF_START;
          end else if (char_i inside {[CH_LO_A:CH_LO_H]}) begin
            state_nxt.ep_sq = {3'd0, char_i[2:0] - 3'd1};
            state_nxt.phase = PH_EP_RANK;
          end else if (char_i != CH_SPACE) begin
            state_nxt.err = 1'b1;
          end
        end
        PH_EP_RANK: begin
          if (char_i == CH_THREE || char_i == CH_SIX) begin
            state_nxt.ep_sq   = {(char_i == CH_THREE) ? RANK_THREE : RANK_SIX,
                                 state_i.ep_sq[2:0]};
            state_nxt.ep_flag = 1'b1;
            state_nxt.phase   = PH_HALF_START;
          end else begin
            state_nxt.err = 1'b1;
          end
        end
        PH_HALF_START: begin
          if (fpp_is_ws(char_i)) begin
            state_nxt.phase = PH_HALF_START;
          end else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
            state_nxt.neg   = (char_i == CH_MINUS);
            state_nxt.phase = PH_HALF_SIGN;
          end else if (fpp_is_digit(char_i)) begin
            state_nxt.neg       = 1'b0;
            state_nxt.clock_val = fpp_accumulate(16'd0, char_i[3:0], 1'b0);
            state_nxt.phase     = PH_HALF_DIGITS;
          end else begin
            state_nxt.phase = PH_DONE;
          end
        end
        PH_HALF_SIGN: begin
          if (fpp_is_digit(char_i)) begin
            state_nxt.clock_val = fpp_accumulate(16'd0, char_i[3:0], state_i.neg);
            state_nxt.phase     = PH_HALF_DIGITS;
          end else begin
            state_nxt.phase = PH_DONE;
          end
        end
        PH_HALF_DIGITS: begin
          if (fpp_is_digit(char_i)) begin
            state_nxt.clock_val = fpp_accumulate(state_i.clock_val, char_i[3:0],
                                                 state_i.neg);
          end else begin
            state_nxt = fpp_move_start(state_i, char_i);
          end
        end
        PH_MOVE_START: begin
          state_nxt = fpp_move_start(state_i, char_i);
        end
        PH_MOVE_SIGN: begin
          if (fpp_is_digit(char_i)) begin
            state_nxt.moves_val = fpp_accumulate(16'd0, char_i[3:0], state_i.neg);
            state_nxt.phase     = PH_MOVE_DIGITS;
          end else begin
            state_nxt.phase = PH_DONE;
          end
        end
        PH_MOVE_DIGITS: begin
          if (fpp_is_digit(char_i)) begin
            state_nxt.moves_val = fpp_accumulate(state_i.moves_val, char_i[3:0],
                                                 state_i.neg);
          end else begin
            state_nxt.phase = PH_DONE;
          end
        end
        default: begin
          state_nxt.phase = PH_DONE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/fpp_out_reg.sv
// Result register of the FEN parser that packs a result into the output stream.
module fpp_out_reg
  import fpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_i,
  input  fpp_result_t        res_i,
  output logic               can_load_o,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tuser
);

  logic        out_valid_r;
  logic        out_valid_nxt;
  fpp_result_t res_r;

  assign can_load_o    = !out_valid_r || out_tready;
  assign out_valid_nxt = load_i || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {1'b0, res_r.move_num, res_r.half_clock, res_r.ep_square,
                       res_r.ep_valid, res_r.castle, res_r.side, res_r.status,
                       res_r.piece, res_r.square};

endmodule

FILE: hdl/fen_position_parser_unit.sv
// Top level of the FEN parser: input register, parser state, step logic and result register.
//
// The parser takes one text byte or end marker per transaction and, unless the input side
// stalls, sustains one transaction per clock cycle; each transaction passes through an input
// register, combinational parsing logic and a result register, so a result is presented on
// the output only after its transaction has been accepted and parsed. A piece letter in the
// placement field yields a placement result, an end marker yields the summary and returns the
// parser to its reset state, and all other bytes yield no result. The input side stalls only
// when a result is waiting and the result register is still full.
module fen_position_parser_unit
  import fpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] character
  input  logic               in_tuser,   // [0] mode
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [5:0] square, [9:6] piece, [10] status,
                                         // [11] side_to_move, [15:12] castling_rights,
                                         // [16] en_passant_valid, [22:17] en_passant_square,
                                         // [38:23] half_move_clock, [54:39] move_number
  output logic               out_tuser   // [0] result_kind
);

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic        in_mode_r;
  logic [7:0]  in_char_r;
  fpp_state_t  state_r;
  fpp_state_t  state_nxt;
  logic        res_valid;
  fpp_result_t res;
  logic        can_load;
  logic        advance;

  assign advance      = in_valid_r && (!res_valid || can_load);
  assign in_tready    = !in_valid_r || advance;
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= FPP_STATE_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_char_r <= in_tdata;
    end
  end

  fpp_step u_step (
    .state_i   (state_r),
    .mode_i    (in_mode_r),
    .char_i    (in_char_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  fpp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (advance && res_valid),
    .res_i      (res),
    .can_load_o (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_err_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.err && !(advance && in_mode_r) |=> state_r.err)
    else $error("Latched format error cleared without an end transaction.");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_mode_r |=> state_r.phase == PH_PLACE && !state_r.err
                             && state_r.rank == RANK_TOP)
    else $error("End transaction did not return the parser to its start state.");

  a_file_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.file <= FILE_END && state_r.phase <= PH_DONE)
    else $error("Parser file or phase out of range.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && res_valid && out_tvalid)
    else $error("Input stalled without a pending result.");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the FEN parser: streams FEN text and checks placements and summaries.
module tb;
  import fpp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_CHAR    = 1'b0;
  localparam logic MODE_END     = 1'b1;
  localparam logic KIND_PLACE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;
  localparam logic SIDE_WHITE   = 1'b0;
  localparam logic SIDE_BLACK   = 1'b1;

  localparam string PIECE_LETTERS  = "KQRBNPkqrbnp";
  localparam string CASTLE_LETTERS = "KQkq";
  localparam string MUTATION_CHARS = "/8 -wbKq3a+5\t9";

  typedef struct {
    logic        kind;
    logic [5:0]  square;
    logic [3:0]  piece;
    logic        status;
    logic        side;
    logic [3:0]  castle;
    logic        ep_valid;
    logic [5:0]  ep_square;
    logic [15:0] half_clock;
    logic [15:0] move_num;
  } fen_result_t;

  class fen_scoreboard;
    logic [3:0]  phase;
    logic        err;
    logic [2:0]  cur_rank;
    logic [3:0]  cur_file;
    logic        colour;
    logic [3:0]  castle;
    logic        ep_flag;
    logic [5:0]  ep_sq;
    logic        neg;
    logic [15:0] half_clk;
    logic [15:0] move_no;

    fen_result_t pending[$];
    int mismatches;
    int checked;
    int placements;
    int summaries;
    int rejected;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      phase    = PH_PLACE;
      err      = 1'b0;
      cur_rank = RANK_TOP;
      cur_file = 4'd0;
      colour   = SIDE_WHITE;
      castle   = 4'd0;
      ep_flag  = 1'b0;
      ep_sq    = 6'd0;
      neg      = 1'b0;
      half_clk = 16'd0;
      move_no  = 16'd0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function int piece_code(logic [7:0] c);
      for (int i = 0; i < PIECE_LETTERS.len(); i++) begin
        if (PIECE_LETTERS[i] == c) return i;
      end
      return -1;
    endfunction

    // Signed decimal shift-in with saturation to the 16-bit range.
    function logic [15:0] decimal_push(logic [15:0] old, logic [7:0] c, logic negative);
      int v;
      int d;
      v = int'($signed(old));
      d = int'(c) - int'(CH_ZERO);
      v = v * 10 + (negative ? -d : d);
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void start_move(logic [7:0] c);
      if (is_blank(c)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg   = (c == CH_MINUS);
        phase = PH_MOVE_SIGN;
      end else if (is_digit(c)) begin
        neg     = 1'b0;
        move_no = decimal_push(16'd0, c, 1'b0);
        phase   = PH_MOVE_DIGITS;
      end else begin
        phase = PH_DONE;
      end
    endfunction

    function void note_input(logic mode, logic [7:0] c);
      fen_result_t r;
      int p;
      logic [4:0] nf;
      r = '{default: '0};
      if (mode == MODE_END) begin
        r.kind = KIND_SUMMARY;
        if (err || phase < PH_HALF_START) begin
          r.status = STATUS_ERROR;
          rejected++;
        end else begin
          r.status     = STATUS_OK;
          r.side       = colour;
          r.castle     = castle;
          r.ep_valid   = ep_flag;
          r.ep_square  = ep_flag ? ep_sq : 6'd0;
          r.half_clock = half_clk;
          r.move_num   = move_no;
        end
        pending.push_back(r);
        summaries++;
        clear_state();
        return;
      end
      if (err || phase >= PH_DONE) return;
      case (phase)
        PH_PLACE: begin
          p = piece_code(c);
          if (c == CH_SPACE) begin
            if (cur_rank != 3'd0) err = 1'b1;
            else phase = PH_COLOUR;
          end else if (c == CH_SLASH) begin
            if (cur_rank == 3'd0) begin
              err = 1'b1;
            end else begin
              cur_rank--;
              cur_file = 4'd0;
            end
          end else if (c >= CH_ONE && c <= CH_EIGHT) begin
            nf = {1'b0, cur_file} + 5'(c - CH_ZERO);
            if (nf > FILE_END) err = 1'b1;
            else cur_file = nf[3:0];
          end else if (p < 0 || cur_file >= FILE_END) begin
            err = 1'b1;
          end else begin
            r.kind   = KIND_PLACE;
            r.square = {cur_rank, cur_file[2:0]};
            r.piece  = p[3:0];
            pending.push_back(r);
            placements++;
            cur_file++;
          end
        end
        PH_COLOUR: begin
          if (c == CH_LO_W) begin
            colour = SIDE_WHITE;
            phase  = PH_CASTLE_START;
          end else if (c == CH_LO_B) begin
            colour = SIDE_BLACK;
            phase  = PH_CASTLE_START;
          end else if (c != CH_SPACE) begin
            err = 1'b1;
          end
        end
        PH_CASTLE_START, PH_CASTLE_LETTERS: begin
          if (c == CH_SPACE) begin
            if (phase == PH_CASTLE_LETTERS) phase = PH_EP_START;
          end else if (c == CH_MINUS && phase == PH_CASTLE_START) begin
            phase = PH_EP_START;
          end else begin
            case (c)
              CH_UP_K: castle |= CASTLE_WK;
              CH_UP_Q: castle |= CASTLE_WQ;
              CH_LO_K: castle |= CASTLE_BK;
              CH_LO_Q: castle |= CASTLE_BQ;
              default: err = 1'b1;
            endcase
            if (!err) phase = PH_CASTLE_LETTERS;
          end
        end
        PH_EP_START: begin
          if (c == CH_MINUS) begin
            ep_flag = 1'b0;
            phase   = PH_HALF_START;
          end else if (c >= CH_LO_A && c <= CH_LO_H) begin
            ep_sq = {3'd0, 3'(c - CH_LO_A)};
            phase = PH_EP_RANK;
          end else if (c != CH_SPACE) begin
            err = 1'b1;
          end
        end
        PH_EP_RANK: begin
          if (c == CH_THREE || c == CH_SIX) begin
            ep_sq   = {(c == CH_THREE) ? RANK_THREE : RANK_SIX, ep_sq[2:0]};
            ep_flag = 1'b1;
            phase   = PH_HALF_START;
          end else begin
            err = 1'b1;
          end
        end
        PH_HALF_START: begin
          if (!is_blank(c)) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              neg   = (c == CH_MINUS);
              phase = PH_HALF_SIGN;
            end else if (is_digit(c)) begin
              neg      = 1'b0;
              half_clk = decimal_push(16'd0, c, 1'b0);
              phase    = PH_HALF_DIGITS;
            end else begin
              phase = PH_DONE;
            end
          end
        end
        PH_HALF_SIGN: begin
          if (is_digit(c)) begin
            half_clk = decimal_push(16'd0, c, neg);
            phase    = PH_HALF_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_HALF_DIGITS: begin
          if (is_digit(c)) begin
            half_clk = decimal_push(half_clk, c, neg);
          end else begin
            phase = PH_MOVE_START;
            start_move(c);
          end
        end
        PH_MOVE_START: start_move(c);
        PH_MOVE_SIGN: begin
          if (is_digit(c)) begin
            move_no = decimal_push(16'd0, c, neg);
            phase   = PH_MOVE_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_MOVE_DIGITS: begin
          if (is_digit(c)) move_no = decimal_push(move_no, c, neg);
          else phase = PH_DONE;
        end
        default: phase = PH_DONE;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0h, expected %0h", checked, name, got, want));
      end
    endtask

    task check_result(logic kind, logic [TDATA_W-1:0] d);
      fen_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected, kind %0d data %h", kind, d));
        return;
      end
      want = pending.pop_front();
      compare("result_kind", kind, want.kind);
      compare("square", d[5:0], want.square);
      compare("piece", d[9:6], want.piece);
      compare("status", d[10], want.status);
      compare("side_to_move", d[11], want.side);
      compare("castling_rights", d[15:12], want.castle);
      compare("en_passant_valid", d[16], want.ep_valid);
      compare("en_passant_square", d[22:17], want.ep_square);
      compare("half_move_clock", d[38:23], want.half_clock);
      compare("move_number", d[54:39], want.move_num);
      compare("padding", d[TDATA_W-1], 1'b0);
      checked++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = 8'd0;
  logic               in_tuser = MODE_CHAR;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  fen_scoreboard sb;
  logic [7:0]    text_q[$];
  int            items_sent = 0;
  int            in_idle_pct = 0;
  int            out_stall_pct = 0;
  int            hold_cycles = 0;

  fen_position_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    end
  end

  task automatic send_item(input logic mode, input logic [7:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(mode, c);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(MODE_CHAR, text_q[i]);
    send_item(MODE_END, 8'($urandom_range(255)));
    text_q.delete();
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_blank();
    text_q.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
  endfunction

  function automatic void add_digits();
    int count;
    count = ($urandom_range(4) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    repeat (count) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
  endfunction

  function automatic void add_number();
    case ($urandom_range(3))
      0: text_q.push_back(CH_PLUS);
      1: text_q.push_back(CH_MINUS);
      default: ;
    endcase
    add_digits();
  endfunction

  function automatic void add_board(int skip_pct);
    int  col;
    int  n;
    bit  short_rank;
    for (int r = 7; r >= 0; r--) begin
      col        = 0;
      short_rank = ($urandom_range(7) == 0);
      while (col < 8) begin
        if (short_rank && $urandom_range(3) == 0) break;
        if ($urandom_range(99) < skip_pct) begin
          n = $urandom_range(1, 8 - col);
          text_q.push_back(8'(CH_ZERO + n));
          col += n;
        end else begin
          text_q.push_back(PIECE_LETTERS[$urandom_range(11)]);
          col++;
        end
      end
      if (r > 0) text_q.push_back(CH_SLASH);
    end
  endfunction

  function automatic void add_numbers_field();
    case ($urandom_range(6))
      0: ;
      1: begin
        add_blank();
        add_number();
      end
      2: begin
        add_blank();
        add_number();
        repeat ($urandom_range(1, 3)) add_blank();
        add_number();
      end
      3: begin
        add_number();
        text_q.push_back(CH_MINUS);
        add_digits();
      end
      4: begin
        add_blank();
        text_q.push_back(8'($urandom_range(CH_LO_A, CH_LO_W)));
        add_digits();
      end
      5: begin
        add_blank();
        text_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        add_blank();
      end
      default: begin
        add_number();
        add_blank();
        add_number();
        repeat ($urandom_range(1, 4)) begin
          text_q.push_back($urandom_range(1) ? 8'd0 : 8'($urandom_range(255)));
        end
      end
    endcase
  endfunction

  function automatic void make_fen(int skip_pct);
    text_q.delete();
    add_board(skip_pct);
    repeat ($urandom_range(1, 2)) text_q.push_back(CH_SPACE);
    text_q.push_back($urandom_range(1) ? CH_LO_W : CH_LO_B);
    if ($urandom_range(1)) text_q.push_back(CH_SPACE);
    if ($urandom_range(3) == 0) begin
      text_q.push_back(CH_MINUS);
      if ($urandom_range(1)) text_q.push_back(CH_SPACE);
    end else begin
      repeat ($urandom_range(1, 4)) text_q.push_back(CASTLE_LETTERS[$urandom_range(3)]);
      text_q.push_back(CH_SPACE);
    end
    if ($urandom_range(2) == 0) begin
      text_q.push_back(CH_MINUS);
    end else begin
      text_q.push_back(8'($urandom_range(CH_LO_A, CH_LO_H)));
      text_q.push_back($urandom_range(1) ? CH_THREE : CH_SIX);
    end
    add_numbers_field();
  endfunction

  function automatic void corrupt_text();
    int idx;
    idx = $urandom_range(text_q.size() - 1);
    if ($urandom_range(1)) text_q[idx] = 8'($urandom_range(255));
    else text_q[idx] = MUTATION_CHARS[$urandom_range(MUTATION_CHARS.len() - 1)];
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int start;
    int pick;
    int keep;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    start         = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        make_fen(50);
      end else if (pick < 85) begin
        make_fen(50);
        repeat ($urandom_range(1, 2)) corrupt_text();
      end else if (pick < 93) begin
        make_fen(50);
        keep = $urandom_range(text_q.size() - 1);
        while (text_q.size() > keep) void'(text_q.pop_back());
      end else begin
        text_q.delete();
        repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(255)));
      end
      send_text();
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text();
    add_str("K");
    send_text();
    add_str("///////p b-h3");
    send_text();
    add_str("9");
    send_text();
    text_q.push_back(8'hFF);
    send_text();

    // Dense board while the receiver holds off, so the result path backs up into the input.
    hold_cycles = 300;
    make_fen(10);
    send_text();

    run_phase(0, 0, 470);
    run_phase(74, 0, 470);
    run_phase(0, 74, 470);
    run_phase(27, 27, 470);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d input transactions: %0d piece placements, %0d summaries (%0d rejected).",
             items_sent, sb.placements, sb.summaries, sb.rejected);
    $display("Traffic ran free, with sender gaps, receiver stalls, both, and one long hold-off.");
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fpp_pkg.sv
hdl/fpp_step.sv
hdl/fpp_out_reg.sv
hdl/fen_position_parser_unit.sv
bench/tb.sv
